@@ design/hnc_pkg.sv @@
// shared types and constants for the harmonic notch cascade
package hnc_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 19;
   localparam int A2_W       = 16;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_STAGES = 3;
   localparam int MCOEF_W    = COEF_W + 1;
   localparam int PROD_W     = MCOEF_W + SAMPLE_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int CSR_ADDR_W = 3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic        [A2_W-1:0]     a2_type;

   typedef struct packed {
      coef_type b1;
      coef_type a1;
      a2_type   a2;
   } stage_coef_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_B1_STAGE1 = 3'd0,
      REG_A1_STAGE1 = 3'd1,
      REG_B1_STAGE2 = 3'd2,
      REG_A1_STAGE2 = 3'd3,
      REG_B1_STAGE3 = 3'd4,
      REG_A1_STAGE3 = 3'd5,
      REG_A2_SHARED = 3'd6
   } reg_idx_type;

   localparam coef_type B1_RESET [NUM_STAGES] = '{
      COEF_W'(-116786), COEF_W'(-92682), COEF_W'(-59505)
   };
   localparam coef_type A1_RESET [NUM_STAGES] = '{
      COEF_W'(-110947), COEF_W'(-88048), COEF_W'(-56530)
   };
   localparam a2_type A2_RESET = A2_W'(59146);

endpackage

@@ design/hnc_cell.sv @@
// one direct-form-i notch biquad cell with a shared multiplier
module hnc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  hnc_pkg::sample_type    x_in,
   input  hnc_pkg::stage_coef_type coef,
   output logic                   done,
   output hnc_pkg::sample_type    y_out
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_B1   = 6'b000010,
      ST_A1   = 6'b000100,
      ST_A2   = 6'b001000,
      ST_ACC  = 6'b010000,
      ST_OUT  = 6'b100000
   } cell_state_type;

   localparam int UPPER_W = hnc_pkg::ACC_W - hnc_pkg::SAMPLE_W + 1;

   cell_state_type state_ff, state_in;
   hnc_pkg::sample_type x0_ff, x1_ff, x2_ff, y1_ff, y2_ff, y_ff;
   logic signed [hnc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [hnc_pkg::ACC_W-1:0]  acc_ff, acc_in, shifted;
   logic signed [hnc_pkg::MCOEF_W-1:0] mult_coef;
   hnc_pkg::sample_type mult_data, sat;
   logic [UPPER_W-1:0] upper;
   logic done_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = start ? ST_B1 : ST_IDLE;
         ST_B1:   state_in = ST_A1;
         ST_A1:   state_in = ST_A2;
         ST_A2:   state_in = ST_ACC;
         ST_ACC:  state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // feedback terms enter negated so the accumulator only adds
   always_comb begin
      case (state_ff)
         ST_B1: begin
            mult_coef = hnc_pkg::MCOEF_W'(coef.b1);
            mult_data = x1_ff;
         end
         ST_A1: begin
            mult_coef = -hnc_pkg::MCOEF_W'(coef.a1);
            mult_data = y1_ff;
         end
         ST_A2: begin
            mult_coef = -$signed({{(hnc_pkg::MCOEF_W - hnc_pkg::A2_W){1'b0}}, coef.a2});
            mult_data = y2_ff;
         end
         default: begin
            mult_coef = '0;
            mult_data = '0;
         end
      endcase
   end

   assign prod_in = hnc_pkg::PROD_W'(mult_coef) * hnc_pkg::PROD_W'(mult_data);

   always_comb begin
      case (state_ff)
         ST_B1:
            acc_in = ((hnc_pkg::ACC_W'(x0_ff) + hnc_pkg::ACC_W'(x2_ff))
                      <<< hnc_pkg::FRAC_BITS)
                     + (hnc_pkg::ACC_W'(1) <<< (hnc_pkg::FRAC_BITS - 1));
         ST_A1, ST_A2, ST_ACC:
            acc_in = acc_ff + hnc_pkg::ACC_W'(prod_ff);
         default:
            acc_in = acc_ff;
      endcase
   end

   // round already added, arithmetic shift gives the floor
   assign shifted = acc_ff >>> hnc_pkg::FRAC_BITS;
   assign upper   = shifted[hnc_pkg::ACC_W-1:hnc_pkg::SAMPLE_W-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         sat = shifted[hnc_pkg::SAMPLE_W-1:0];
      end else if (upper[UPPER_W-1]) begin
         sat = {1'b1, {(hnc_pkg::SAMPLE_W - 1){1'b0}}};
      end else begin
         sat = {1'b0, {(hnc_pkg::SAMPLE_W - 1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         x1_ff    <= '0;
         x2_ff    <= '0;
         y1_ff    <= '0;
         y2_ff    <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == ST_OUT);
         if (state_ff == ST_OUT) begin
            x1_ff <= x0_ff;
            x2_ff <= x1_ff;
            y1_ff <= sat;
            y2_ff <= y1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         x0_ff <= x_in;
      end
      if (state_ff == ST_OUT) begin
         y_ff <= sat;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done  = done_ff;
   assign y_out = y_ff;

endmodule

@@ design/harmonic_notch_cascade.sv @@
// three cascaded notch biquad cells with coefficient registers and output register
// flow: one sample in flight at a time; a new one is accepted only once the result is
// loaded into the output register, which waits for rsp_tready; each of the three cells
// runs its three products through one 20x16 multiplier
// reset: synchronous, clears filter history and control, coefficients take defaults
module harmonic_notch_cascade (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // sample_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // sample_out
   input  logic                              csr_we,
   input  logic [hnc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [hnc_pkg::COEF_W-1:0]        csr_wdata
);

   hnc_pkg::coef_type b1_ff [hnc_pkg::NUM_STAGES];
   hnc_pkg::coef_type a1_ff [hnc_pkg::NUM_STAGES];
   hnc_pkg::a2_type   a2_ff;

   logic busy_ff, busy_in;
   logic pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   hnc_pkg::sample_type rsp_data_ff;

   logic                start_chain [hnc_pkg::NUM_STAGES+1];
   hnc_pkg::sample_type data_chain  [hnc_pkg::NUM_STAGES+1];

   logic accept, finished, load;

   assign accept   = req_tvalid && req_tready;
   assign finished = start_chain[hnc_pkg::NUM_STAGES] || pend_ff;
   assign load     = finished && (!rsp_valid_ff || rsp_tready);

   assign start_chain[0] = accept;
   assign data_chain[0]  = req_tdata;

   for (genvar s = 0; s < hnc_pkg::NUM_STAGES; s++) begin : g_stage
      hnc_pkg::stage_coef_type coef;
      assign coef = '{b1: b1_ff[s], a1: a1_ff[s], a2: a2_ff};
      hnc_cell u_cell (
         .clock (clock),
         .reset (reset),
         .start (start_chain[s]),
         .x_in  (data_chain[s]),
         .coef  (coef),
         .done  (start_chain[s+1]),
         .y_out (data_chain[s+1])
      );
   end

   always_comb begin
      busy_in      = busy_ff;
      pend_in      = finished && !load;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (load) begin
         busy_in = 1'b0;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= data_chain[hnc_pkg::NUM_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < hnc_pkg::NUM_STAGES; s++) begin
            b1_ff[s] <= hnc_pkg::B1_RESET[s];
            a1_ff[s] <= hnc_pkg::A1_RESET[s];
         end
         a2_ff <= hnc_pkg::A2_RESET;
      end else if (csr_we) begin
         case (hnc_pkg::reg_idx_type'(csr_addr))
            hnc_pkg::REG_B1_STAGE1: b1_ff[0] <= csr_wdata;
            hnc_pkg::REG_A1_STAGE1: a1_ff[0] <= csr_wdata;
            hnc_pkg::REG_B1_STAGE2: b1_ff[1] <= csr_wdata;
            hnc_pkg::REG_A1_STAGE2: a1_ff[1] <= csr_wdata;
            hnc_pkg::REG_B1_STAGE3: b1_ff[2] <= csr_wdata;
            hnc_pkg::REG_A1_STAGE3: a1_ff[2] <= csr_wdata;
            hnc_pkg::REG_A2_SHARED: a2_ff    <= csr_wdata[hnc_pkg::A2_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ test/notch_cascade_checker.sv @@
// checker for the harmonic notch cascade: mirrors the coefficient registers, predicts and compares
module notch_cascade_checker
   import hnc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [15:0]           req_tdata,  // sample_in
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,  // sample_out
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [COEF_W-1:0]     csr_wdata,
   output int                    mismatch_count,
   output int                    pending_samples
);

   coef_type   b1_coef [NUM_STAGES];
   coef_type   a1_coef [NUM_STAGES];
   a2_type     a2_coef;
   sample_type in_hist [2];
   sample_type cell_hist [2*NUM_STAGES];
   sample_type expected_samples [$];

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // one notch cell: b0 = b2 = 1, round half up, saturate
   function automatic sample_type notch_cell(input sample_type x0, input sample_type x1,
                                             input sample_type x2, input sample_type y1,
                                             input sample_type y2, input coef_type b1,
                                             input coef_type a1, input a2_type a2);
      longint     acc;
      longint     hi;
      longint     lo;
      sample_type result;
      acc = (longint'(x0) + longint'(x2)) <<< FRAC_BITS;
      acc = acc + longint'(b1) * longint'(x1) - longint'(a1) * longint'(y1)
                - longint'(a2) * longint'(y2);
      acc = acc + (longint'(1) <<< (FRAC_BITS - 1));
      acc = acc >>> FRAC_BITS;
      hi  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
      lo  = -hi - 1;
      if (acc > hi) begin
         result = sample_type'(hi);
      end else if (acc < lo) begin
         result = sample_type'(lo);
      end else begin
         result = sample_type'(acc);
      end
      return result;
   endfunction

   function automatic sample_type predict_output(input sample_type x_in);
      sample_type x;
      sample_type y;
      sample_type xh1;
      sample_type xh2;
      x   = x_in;
      xh1 = in_hist[0];
      xh2 = in_hist[1];
      for (int s = 0; s < NUM_STAGES; s++) begin
         y = notch_cell(x, xh1, xh2, cell_hist[2*s], cell_hist[2*s+1],
                        b1_coef[s], a1_coef[s], a2_coef);
         // next cell sees this cell's old outputs as its input history
         xh1 = cell_hist[2*s];
         xh2 = cell_hist[2*s+1];
         if (s == 0) begin
            in_hist[1] = in_hist[0];
            in_hist[0] = x;
         end
         cell_hist[2*s+1] = cell_hist[2*s];
         cell_hist[2*s]   = y;
         x = y;
      end
      return x;
   endfunction

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            b1_coef[s] = B1_RESET[s];
            a1_coef[s] = A1_RESET[s];
         end
         a2_coef = A2_RESET;
         in_hist = '{default: '0};
         cell_hist = '{default: '0};
         expected_samples.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_B1_STAGE1: b1_coef[0] = coef_type'(csr_wdata);
               REG_A1_STAGE1: a1_coef[0] = coef_type'(csr_wdata);
               REG_B1_STAGE2: b1_coef[1] = coef_type'(csr_wdata);
               REG_A1_STAGE2: a1_coef[1] = coef_type'(csr_wdata);
               REG_B1_STAGE3: b1_coef[2] = coef_type'(csr_wdata);
               REG_A1_STAGE3: a1_coef[2] = coef_type'(csr_wdata);
               REG_A2_SHARED: a2_coef    = csr_wdata[A2_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("unexpected sample_out %0d",
                                         $signed(rsp_tdata)));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata !== want) begin
                  report_mismatch($sformatf("sample_out got %0d expected %0d",
                                            $signed(rsp_tdata), want));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_samples.push_back(predict_output(sample_type'(req_tdata)));
         end
      end
      pending_samples = expected_samples.size();
   end

endmodule

@@ test/tb_harmonic_notch_cascade.sv @@
// testbench top for the harmonic notch cascade: stimulus, coefficient loads and verdict
module tb_harmonic_notch_cascade;
   import hnc_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] NO_SUCH_REG = 3'd7;
   localparam int COEF_MAX       = 262143;
   localparam int COEF_MIN       = -262144;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 50;
   localparam int PLAIN_SET [10] = '{0, 32767, 32767, 32767, -32768, -32768, 1, -1, 0, 0};
   localparam int STEEP_SET [8]  = '{32767, -32768, 1, 0, -1, 12345, 0, 0};
   localparam int FLAT_SET [6]   = '{-32768, 32767, -32768, 32767, 0, 0};

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;  // sample_in
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;  // sample_out
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [COEF_W-1:0]     csr_wdata;
   int                    mismatches;
   int                    pending_samples;
   logic                  idling;
   int                    stall_left = 0;
   int                    quiet_cycles;

   harmonic_notch_cascade dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   notch_cascade_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatches),
      .pending_samples (pending_samples)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idling && $urandom_range(0, 11) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_sample(input sample_type value);
      int gap;
      @(negedge clock);
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_samples != 0) @(negedge clock);
   endtask

   // unused index goes last so an aliased write would clobber a live register
   task automatic load_coefs(input logic [COEF_W-1:0] b1 [NUM_STAGES],
                             input logic [COEF_W-1:0] a1 [NUM_STAGES],
                             input logic [COEF_W-1:0] a2_raw,
                             input logic [COEF_W-1:0] junk);
      logic [CSR_ADDR_W-1:0] idx [8];
      logic [COEF_W-1:0]     val [8];
      idx = '{REG_B1_STAGE1, REG_A1_STAGE1, REG_B1_STAGE2, REG_A1_STAGE2,
              REG_B1_STAGE3, REG_A1_STAGE3, REG_A2_SHARED, NO_SUCH_REG};
      val = '{b1[0], a1[0], b1[1], a1[1], b1[2], a1[2], a2_raw, junk};
      for (int i = 0; i < 8; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= idx[i];
         csr_wdata <= val[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      logic [COEF_W-1:0] b1_set [NUM_STAGES];
      logic [COEF_W-1:0] a1_set [NUM_STAGES];
      logic [COEF_W-1:0] a2_raw;
      longint            b;
      longint            k;
      int                pick;
      sample_type        value;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      idling     = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default notch coefficients from reset
      for (int i = 0; i < 10; i++) send_sample(sample_type'(PLAIN_SET[i]));
      wait_for_drain();

      // max feedforward, min feedback, a2 with excess bits set
      for (int s = 0; s < NUM_STAGES; s++) begin
         b1_set[s] = COEF_W'(COEF_MAX);
         a1_set[s] = COEF_W'(COEF_MIN);
      end
      load_coefs(b1_set, a1_set, '1, '1);
      for (int i = 0; i < 8; i++) send_sample(sample_type'(STEEP_SET[i]));
      wait_for_drain();

      // min feedforward, max feedback, a2 zero after masking
      for (int s = 0; s < NUM_STAGES; s++) begin
         b1_set[s] = COEF_W'(COEF_MIN);
         a1_set[s] = COEF_W'(COEF_MAX);
      end
      load_coefs(b1_set, a1_set, 19'h70000, 19'h2AAAA);
      for (int i = 0; i < 6; i++) send_sample(sample_type'(FLAT_SET[i]));
      wait_for_drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idling = !(p == 2 || p == 5 || p == RANDOM_PHASES - 1);
         case (p % 3)
            0: begin
               // realistic notch: a1 = R*b1, a2 = R*R
               k = $urandom_range(45875, 65535);
               for (int s = 0; s < NUM_STAGES; s++) begin
                  b = longint'($urandom_range(0, 262143)) - 131072;
                  b1_set[s] = COEF_W'(b);
                  a1_set[s] = COEF_W'((b * k) >>> 16);
               end
               a2_raw = COEF_W'((k * k) >>> 16);
            end
            1: begin
               for (int s = 0; s < NUM_STAGES; s++) begin
                  b1_set[s] = COEF_W'($urandom);
                  a1_set[s] = COEF_W'($urandom);
               end
               a2_raw = COEF_W'($urandom);
            end
            default: begin
               for (int s = 0; s < NUM_STAGES; s++) begin
                  b1_set[s] = COEF_W'($urandom);
                  a1_set[s] = COEF_W'(int'($urandom_range(0, 65535)) - 32768);
               end
               a2_raw = COEF_W'($urandom_range(0, 65535));
            end
         endcase
         load_coefs(b1_set, a1_set, a2_raw, COEF_W'($urandom));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 7);
            if (pick < 4) begin
               value = sample_type'($urandom);
            end else if (pick < 6) begin
               value = sample_type'(int'($urandom_range(0, 511)) - 256);
            end else if (pick == 6) begin
               value = $urandom_range(0, 1) ? sample_type'(32767) : sample_type'(-32768);
            end else begin
               value = sample_type'(int'($urandom_range(0, 16383)) - 8192);
            end
            send_sample(value);
         end
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending_samples == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
